@@ src/ball_peg_collision_step_assert.svh @@
// Assertion macros for the ball and peg collision step.
// Depends on clk_i and rst_ni in the scope of the including module.
`ifndef BALL_PEG_COLLISION_STEP_ASSERT_SVH
`define BALL_PEG_COLLISION_STEP_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define BPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ src/bpc_pkg.sv @@
// Package for the ball and peg collision step: sequencer states, Q16.15
// constants and register indexes. No dependencies.
package bpc_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PEG, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_CHK, ST_DIVX, ST_DIVY,
    ST_MX, ST_MY, ST_MR, ST_MRY, ST_MVX, ST_MVY, ST_FIN
  } state_e;

  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CFG_GRAVITY = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CONTACT = 8'd1;

  localparam logic [15:0] GRAVITY_RESET = 16'd12124;
  localparam logic [20:0] CONTACT_RESET = 21'd327680;

  localparam logic [31:0] Q_ONE      = 32'd32768;
  localparam logic [31:0] PEG_X0     = 32'd10485760;
  localparam logic [31:0] PEG_Y0     = 32'd3276800;
  localparam logic [31:0] PEG_HSTEP  = 32'd1245184;
  localparam logic [31:0] PEG_HSTEP2 = 32'd2490368;
  localparam logic [31:0] PEG_VSTEP  = 32'd622592;
  localparam logic [31:0] FIELD_BOT  = 32'd15728640;
  localparam logic [31:0] FIELD_RGT  = 32'd20971520;
  localparam logic [31:0] FIELD_CTR  = 32'd10485760;
  localparam logic [31:0] WALL_NUDGE = 32'd163840;

  localparam int SubW      = 26;
  localparam int RadW      = 44;
  localparam int DistW     = 22;
  localparam int NumW      = 36;
  localparam int CntW      = 6;
  localparam int SqrtSteps = 22;
  localparam int DivSteps  = 36;

endpackage

@@ src/bpc_channels.sv @@
// Channel interfaces for the ball and peg collision step: input item,
// result item and configuration write. No dependencies.
interface bpc_ball_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [15:0] spawn_speed;
  modport source (output valid, pos_x, pos_y, vel_x, vel_y, spawn_speed, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, spawn_speed, output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] next_x;
  logic signed [31:0] next_y;
  logic signed [31:0] next_vx;
  logic signed [31:0] next_vy;
  logic               respawned;
  logic               touched_peg;
  modport source (output valid, next_x, next_y, next_vx, next_vy, respawned, touched_peg,
                  input ready);
  modport sink   (input valid, next_x, next_y, next_vx, next_vy, respawned, touched_peg,
                  output ready);
endinterface

interface bpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/ball_peg_collision_step.sv @@
// Top level of the ball and peg collision step: sequencer, shared multiplier
// and shared subtractor. Depends on bpc_pkg, bpc_channels and the assert header.
//
// Usage:
//   ball_i carries one ball state (position, velocity, spawn speed); ball_o
//   returns the advanced state with respawn and peg contact flags; cfg_i
//   writes gravity (index 0) and contact distance (index 1), other indexes
//   are dropped. cfg_i is always ready.
//   One item is taken while the sequencer is idle. Each peg is checked for
//   range; a peg in range has its squares summed and is done on a zero
//   sum, else takes a square root and is done when out of reach; on contact
//   it divides and reflects: 22 square root and 2 x 36 division steps on one
//   shared subtractor, plus eight passes through one 32 x 32 multiplier.
//   With 16 levels the walk covers 136 pegs; after a contact on the last peg
//   the final state also waits for the last velocity product.
//   The result sits in an output register; ball_i is ready again the cycle
//   after the result is loaded, even while ball_o is stalled. A stalled
//   ball_o holds the next item in the final state until the register frees.
//   Reset clears the sequencer and output valid and loads the register
//   defaults: gravity 12124, contact distance 327680.
`include "ball_peg_collision_step_assert.svh"

module ball_peg_collision_step #(
  parameter int LEVELS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpc_ball_if.sink      ball_i,
  bpc_result_if.source  ball_o,
  bpc_cfg_if.sink       cfg_i
);

  localparam int LvlW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LvlW-1:0] LvlLast = LvlW'(LEVELS - 1);

  bpc_pkg::state_e state_q, state_d;

  logic [15:0] grav_q;
  logic [20:0] sep_q;

  logic [31:0] x_q, y_q, vx_q, vy_q, sp_q;
  logic [31:0] px_q, py_q, pxrow_q;
  logic [LvlW-1:0] lvl_q, col_q;
  logic [31:0] dx_q, dy_q, acc_q, nx_q, ny_q, refl_q;
  logic signed [63:0] p_q;
  logic [bpc_pkg::RadW-1:0]  rad_q;
  logic [bpc_pkg::SubW-1:0]  rem_q;
  logic [bpc_pkg::DistW-1:0] root_q;
  logic [bpc_pkg::NumW-1:0]  num_q, quo_q;
  logic neg_q;
  logic [bpc_pkg::CntW-1:0] cnt_q;
  logic touched_q;
  logic pvy_pending_q;

  logic        out_valid_q;
  logic [31:0] ox_q, oy_q, ovx_q, ovy_q;
  logic        oresp_q, otouch_q;

  // combinational helpers
  logic [31:0] dx_c, dy_c, mdx_c, mdy_c, pq_c, s_c, reach_c, dot_c;
  logic        near_c, last_peg_c, out_free_c, fin_load_c;
  logic [31:0] mul_a, mul_b;
  logic signed [63:0] prod_c;
  logic [bpc_pkg::SubW-1:0] sub_a, sub_b, rem_sh;
  logic [bpc_pkg::SubW:0]   diff_c;
  logic        ge_c;
  logic [31:0] fx, fy, fvx, fvy;
  logic        fresp;

  assign dx_c   = x_q - px_q;
  assign dy_c   = y_q - py_q;
  assign mdx_c  = dx_c[31] ? (32'd0 - dx_c) : dx_c;
  assign mdy_c  = dy_c[31] ? (32'd0 - dy_c) : dy_c;
  assign near_c = (mdx_c < {11'd0, sep_q}) && (mdy_c < {11'd0, sep_q});
  assign last_peg_c = (col_q == lvl_q) && (lvl_q == LvlLast);
  assign pq_c   = p_q[46:15];
  assign s_c    = acc_q + pq_c;
  assign reach_c = {11'd0, sep_q} + bpc_pkg::Q_ONE;
  assign dot_c  = acc_q + pq_c;
  assign out_free_c = !out_valid_q || ball_o.ready;
  assign fin_load_c = (state_q == bpc_pkg::ST_FIN) && out_free_c && !pvy_pending_q;

  // shared multiplier operands
  always_comb begin
    mul_a = nx_q;
    mul_b = vx_q;
    unique case (state_q)
      bpc_pkg::ST_SQX: begin mul_a = dx_q; mul_b = dx_q;    end
      bpc_pkg::ST_SQY: begin mul_a = dy_q; mul_b = dy_q;    end
      bpc_pkg::ST_MX:  begin mul_a = nx_q; mul_b = vx_q;    end
      bpc_pkg::ST_MY:  begin mul_a = ny_q; mul_b = vy_q;    end
      bpc_pkg::ST_MR:  begin mul_a = nx_q; mul_b = reach_c; end
      bpc_pkg::ST_MRY: begin mul_a = ny_q; mul_b = reach_c; end
      bpc_pkg::ST_MVX: begin mul_a = nx_q; mul_b = refl_q;  end
      bpc_pkg::ST_MVY: begin mul_a = ny_q; mul_b = refl_q;  end
      default: ;
    endcase
  end
  assign prod_c = $signed(mul_a) * $signed(mul_b);

  // shared compare and subtract
  always_comb begin
    if (state_q == bpc_pkg::ST_SQRT) begin
      rem_sh = {rem_q[bpc_pkg::SubW-3:0], rad_q[bpc_pkg::RadW-1 -: 2]};
      sub_b  = {2'd0, root_q, 2'b01};
    end else begin
      rem_sh = {rem_q[bpc_pkg::SubW-2:0], num_q[bpc_pkg::NumW-1]};
      sub_b  = {4'd0, root_q};
    end
    sub_a  = rem_sh;
    diff_c = {1'b0, sub_a} - {1'b0, sub_b};
    ge_c   = !diff_c[bpc_pkg::SubW];
  end

  // floor, ceiling and side walls, then gravity
  always_comb begin
    fx = x_q; fy = y_q; fvx = vx_q; fvy = vy_q; fresp = 1'b0;
    if ($signed(fy) > $signed(bpc_pkg::FIELD_BOT)) begin
      fx = bpc_pkg::FIELD_CTR; fy = 32'd0; fvx = sp_q; fvy = 32'd0; fresp = 1'b1;
    end
    if (fy[31]) begin
      fvy = 32'd0 - fvy; fy = fy + bpc_pkg::WALL_NUDGE;
    end
    if ($signed(fx) > $signed(bpc_pkg::FIELD_RGT)) begin
      fvx = 32'd0 - fvx; fx = fx - bpc_pkg::WALL_NUDGE;
    end
    if (fx[31]) begin
      fvx = 32'd0 - fvx; fx = fx + bpc_pkg::WALL_NUDGE;
    end
    fvy = fvy + {16'd0, grav_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpc_pkg::ST_IDLE: if (ball_i.valid) state_d = bpc_pkg::ST_PEG;
      bpc_pkg::ST_PEG: begin
        if (near_c) state_d = bpc_pkg::ST_SQX;
        else if (last_peg_c) state_d = bpc_pkg::ST_FIN;
      end
      bpc_pkg::ST_SQX: state_d = bpc_pkg::ST_SQY;
      bpc_pkg::ST_SQY: state_d = bpc_pkg::ST_SUM;
      bpc_pkg::ST_SUM: begin
        if (!s_c[31] && (s_c != 32'd0)) state_d = bpc_pkg::ST_SQRT;
        else if (last_peg_c) state_d = bpc_pkg::ST_FIN;
        else state_d = bpc_pkg::ST_PEG;
      end
      bpc_pkg::ST_SQRT:
        if (cnt_q == bpc_pkg::CntW'(bpc_pkg::SqrtSteps - 1)) state_d = bpc_pkg::ST_CHK;
      bpc_pkg::ST_CHK: begin
        if ((root_q != '0) && (root_q < {1'b0, sep_q})) state_d = bpc_pkg::ST_DIVX;
        else if (last_peg_c) state_d = bpc_pkg::ST_FIN;
        else state_d = bpc_pkg::ST_PEG;
      end
      bpc_pkg::ST_DIVX:
        if (cnt_q == bpc_pkg::CntW'(bpc_pkg::DivSteps - 1)) state_d = bpc_pkg::ST_DIVY;
      bpc_pkg::ST_DIVY:
        if (cnt_q == bpc_pkg::CntW'(bpc_pkg::DivSteps - 1)) state_d = bpc_pkg::ST_MX;
      bpc_pkg::ST_MX:  state_d = bpc_pkg::ST_MY;
      bpc_pkg::ST_MY:  state_d = bpc_pkg::ST_MR;
      bpc_pkg::ST_MR:  state_d = bpc_pkg::ST_MRY;
      bpc_pkg::ST_MRY: state_d = bpc_pkg::ST_MVX;
      bpc_pkg::ST_MVX: state_d = bpc_pkg::ST_MVY;
      bpc_pkg::ST_MVY: state_d = last_peg_c ? bpc_pkg::ST_FIN : bpc_pkg::ST_PEG;
      bpc_pkg::ST_FIN: if (fin_load_c) state_d = bpc_pkg::ST_IDLE;
      default: state_d = bpc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= bpc_pkg::GRAVITY_RESET;
      sep_q  <= bpc_pkg::CONTACT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        bpc_pkg::CFG_GRAVITY: grav_q <= cfg_i.data[15:0];
        bpc_pkg::CFG_CONTACT: sep_q  <= cfg_i.data[20:0];
        default: ;
      endcase
    end
  end

  // peg walk: advance after a peg is done
  logic adv_c;
  always_comb begin
    adv_c = 1'b0;
    unique case (state_q)
      bpc_pkg::ST_PEG:  adv_c = !near_c;
      bpc_pkg::ST_SUM:  adv_c = s_c[31] || (s_c == 32'd0);
      bpc_pkg::ST_CHK:  adv_c = (root_q == '0) || (root_q >= {1'b0, sep_q});
      bpc_pkg::ST_MVY:  adv_c = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q     <= '0;
      col_q     <= '0;
      touched_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (state_q == bpc_pkg::ST_IDLE) begin
        lvl_q <= '0; col_q <= '0; touched_q <= 1'b0;
      end else if (adv_c) begin
        if (col_q == lvl_q) begin
          col_q <= '0;
          lvl_q <= lvl_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (state_q == bpc_pkg::ST_MVY) touched_q <= 1'b1;
      if ((state_q == bpc_pkg::ST_SQRT) || (state_q == bpc_pkg::ST_DIVX) ||
          (state_q == bpc_pkg::ST_DIVY)) begin
        cnt_q <= (state_q != state_d) ? '0 : cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    p_q <= prod_c;
    if ((state_q == bpc_pkg::ST_IDLE) && ball_i.valid) begin
      x_q  <= ball_i.pos_x + ball_i.vel_x;
      y_q  <= ball_i.pos_y + ball_i.vel_y;
      vx_q <= ball_i.vel_x;
      vy_q <= ball_i.vel_y;
      sp_q <= {{16{ball_i.spawn_speed[15]}}, ball_i.spawn_speed};
      px_q    <= bpc_pkg::PEG_X0;
      pxrow_q <= bpc_pkg::PEG_X0;
      py_q    <= bpc_pkg::PEG_Y0;
    end else if (adv_c) begin
      if (col_q == lvl_q) begin
        pxrow_q <= pxrow_q - bpc_pkg::PEG_HSTEP;
        px_q    <= pxrow_q - bpc_pkg::PEG_HSTEP;
        py_q    <= py_q + bpc_pkg::PEG_VSTEP;
      end else begin
        px_q <= px_q + bpc_pkg::PEG_HSTEP2;
      end
    end
    unique case (state_q)
      bpc_pkg::ST_PEG: begin
        dx_q <= dx_c;
        dy_q <= dy_c;
      end
      bpc_pkg::ST_SQY: acc_q <= pq_c;
      bpc_pkg::ST_SUM: begin
        rad_q  <= {s_c[28:0], 15'd0};
        rem_q  <= '0;
        root_q <= '0;
      end
      bpc_pkg::ST_SQRT: begin
        rad_q  <= {rad_q[bpc_pkg::RadW-3:0], 2'b00};
        rem_q  <= ge_c ? diff_c[bpc_pkg::SubW-1:0] : rem_sh;
        root_q <= {root_q[bpc_pkg::DistW-2:0], ge_c};
      end
      bpc_pkg::ST_CHK: begin
        rem_q <= '0;
        quo_q <= '0;
        neg_q <= dx_q[31];
        num_q <= {mdx_c_of(dx_q), 15'd0};
      end
      bpc_pkg::ST_DIVX, bpc_pkg::ST_DIVY: begin
        if (state_q != state_d) begin
          rem_q <= '0;
          quo_q <= '0;
          if (state_q == bpc_pkg::ST_DIVX) begin
            nx_q  <= quo_next(neg_q, quo_q, ge_c);
            neg_q <= dy_q[31];
            num_q <= {mdx_c_of(dy_q), 15'd0};
          end else begin
            ny_q <= quo_next(neg_q, quo_q, ge_c);
          end
        end else begin
          rem_q <= ge_c ? diff_c[bpc_pkg::SubW-1:0] : rem_sh;
          quo_q <= {quo_q[bpc_pkg::NumW-2:0], ge_c};
          num_q <= {num_q[bpc_pkg::NumW-2:0], 1'b0};
        end
      end
      bpc_pkg::ST_MY:  acc_q  <= pq_c;
      bpc_pkg::ST_MR:  refl_q <= 32'd0 - {dot_c[30:0], 1'b0};
      bpc_pkg::ST_MRY: x_q    <= px_q + pq_c;
      bpc_pkg::ST_MVX: y_q    <= py_q + pq_c;
      bpc_pkg::ST_MVY: vx_q   <= vx_q + pq_c;
      default: ;
    endcase
    if (pvy_pending_q) vy_q <= vy_q + pq_c;
  end

  // the last velocity product lands in the cycle after ST_MVY
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvy_pending_q <= 1'b0;
    end else begin
      pvy_pending_q <= (state_q == bpc_pkg::ST_MVY);
    end
  end

  function automatic logic [20:0] mdx_c_of(input logic [31:0] d);
    logic [31:0] m;
    m = d[31] ? (32'd0 - d) : d;
    return m[20:0];
  endfunction

  function automatic logic [31:0] quo_next(input logic n,
                                           input logic [bpc_pkg::NumW-1:0] q,
                                           input logic g);
    logic [31:0] v;
    v = {q[30:0], g};
    return n ? (32'd0 - v) : v;
  endfunction

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load_c) begin
      out_valid_q <= 1'b1;
    end else if (ball_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load_c) begin
      ox_q     <= fx;
      oy_q     <= fy;
      ovx_q    <= fvx;
      ovy_q    <= fvy;
      oresp_q  <= fresp;
      otouch_q <= touched_q;
    end
  end

  assign ball_i.ready      = (state_q == bpc_pkg::ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign ball_o.valid      = out_valid_q;
  assign ball_o.next_x     = ox_q;
  assign ball_o.next_y     = oy_q;
  assign ball_o.next_vx    = ovx_q;
  assign ball_o.next_vy    = ovy_q;
  assign ball_o.respawned  = oresp_q;
  assign ball_o.touched_peg = otouch_q;

  `BPC_ASSERT(a_accept_starts_walk,
    (ball_i.valid && ball_i.ready) |=> (state_q == bpc_pkg::ST_PEG), "accept did not start walk")
  `BPC_ASSERT(a_sqrt_bound,
    (state_q == bpc_pkg::ST_SQRT) |-> (cnt_q < bpc_pkg::CntW'(bpc_pkg::SqrtSteps)),
    "square root ran too long")
  `BPC_ASSERT(a_contact_nonzero,
    (state_q == bpc_pkg::ST_MX) |-> (root_q != '0), "contact with zero distance")
  `BPC_ASSERT_ALWAYS(a_reset_idle,
    !rst_ni |=> (state_q == bpc_pkg::ST_IDLE), "sequencer not idle in reset")

endmodule
